[src/engine_rpm_torque_step_assert.svh]
// Assertion macros shared by the engine speed and torque block.
`ifndef ENGINE_RPM_TORQUE_STEP_ASSERT_SVH
`define ENGINE_RPM_TORQUE_STEP_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define ERTS_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("engine speed block check failed");

// Condition must hold in the cycle after the trigger.
`define ERTS_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("engine speed block check failed");

`endif

[src/erts_pkg.sv]
package erts_pkg;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RPM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TORQUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_TQ   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_RPM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INERTIA    = 3'd5;

    // Fixed-point constants.
    localparam logic [19:0] RPM_PER_RADS = 20'd625823;
    localparam logic [16:0] ONE_Q16      = 17'd65536;
    localparam logic [16:0] CURVE_MIN    = 17'd13107;
    localparam logic [16:0] PEN_MAX      = 17'd52429;
    localparam logic [24:0] GEARED_CAP   = 25'h1000000;
    localparam logic [18:0] PEAK_MIN     = 19'd16;

    // Shared arithmetic units.
    localparam int unsigned MUL_A_W = 40;
    localparam int unsigned MUL_B_W = 24;
    localparam int unsigned PROD_W  = 64;
    localparam int unsigned DIV_N_W = 64;
    localparam int unsigned DIV_D_W = 48;

    // Sequencer steps, one unit operation each.
    localparam int unsigned STEP_W = 4;
    localparam int unsigned NUM_STEPS = 16;
    localparam logic [STEP_W-1:0] STEP_GEAR_A  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_GEAR_B  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ACC_A   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ACC_B   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ACC_DIV = 4'd4;
    localparam logic [STEP_W-1:0] STEP_BLEND   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_U_SQ    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_U_SQ9   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_P_SQ    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_P_SQ20  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_PEN_DIV = 4'd10;
    localparam logic [STEP_W-1:0] STEP_FRAC    = 4'd11;
    localparam logic [STEP_W-1:0] STEP_DRIVE_A = 4'd12;
    localparam logic [STEP_W-1:0] STEP_DRIVE_B = 4'd13;
    localparam logic [STEP_W-1:0] STEP_BRAKE_A = 4'd14;
    localparam logic [STEP_W-1:0] STEP_BRAKE_B = 4'd15;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_FINAL,
        S_EMIT
    } seq_state_t;

    // Status of a shared arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

[src/erts_chan_if.sv]
interface erts_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [15:0]        time_step;
    logic [16:0]        throttle;
    logic [16:0]        clutch_lock;
    logic               gear_engaged;
    logic signed [17:0] gear_ratio;
    logic signed [19:0] wheel_speed;

    modport source (
        output valid, action, time_step, throttle, clutch_lock, gear_engaged,
               gear_ratio, wheel_speed,
        input  ready
    );
    modport sink (
        input  valid, action, time_step, throttle, clutch_lock, gear_engaged,
               gear_ratio, wheel_speed,
        output ready
    );
endinterface

interface erts_out_if;
    logic               valid;
    logic               ready;
    logic [18:0]        engine_speed;
    logic signed [16:0] engine_torque_out;
    logic               limiter_on;

    modport source (
        output valid, engine_speed, engine_torque_out, limiter_on,
        input  ready
    );
    modport sink (
        input  valid, engine_speed, engine_torque_out, limiter_on,
        output ready
    );
endinterface

[src/engine_rpm_torque_step.sv]
// Channel  | Role   | Handshake    | Item
// in_ch    | sink   | valid/ready  | action, tick inputs
// out_ch   | source | valid/ready  | engine_speed, engine_torque_out, limiter_on
// cfg      | write  | cfg_we       | cfg_index, cfg_data
//
// An advance item runs 16 serial operations: 13 on one bit-serial multiplier
// and 3 on one restoring divider; the sequencer issues each and waits for it.
// Restart items and items before the first restart skip the operations.
// Reset is asynchronous and active low; there is no clearing pass.
// The result sits in an output register; the block waits only when that
// register is still full at the end of the next item.
module engine_rpm_torque_step (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [erts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [erts_pkg::CFG_DATA_W-1:0] cfg_data,
    erts_in_if.sink                         in_ch,
    erts_out_if.source                      out_ch
);

    `include "engine_rpm_torque_step_assert.svh"

    localparam int unsigned FS_W = 36;

    // Configuration registers.
    logic [18:0] idle_reg;
    logic [18:0] max_reg;
    logic [15:0] max_tq_reg;
    logic [15:0] brake_tq_reg;
    logic [18:0] peak_reg;
    logic [17:0] inertia_reg;

    // Engine state.
    logic [18:0]        speed_reg;
    logic signed [16:0] torque_reg;
    logic               limiter_reg;
    logic               started_reg;

    // Sequencer.
    erts_pkg::seq_state_t              state_reg;
    erts_pkg::seq_state_t              state_next;
    logic [erts_pkg::STEP_W-1:0]       step_reg;
    logic                              mul_start;
    logic                              div_start;
    logic                              step_is_div;
    logic                              unit_done;
    logic [erts_pkg::PROD_W-1:0]       unit_res;
    logic                              slot_free;

    // Latched item and intermediate results.
    logic [15:0]               dt_reg;
    logic [16:0]               thr_reg;
    logic [16:0]               lock_reg;
    logic                      engaged_reg;
    logic signed [17:0]        ratio_reg;
    logic signed [19:0]        wheel_reg;
    logic [erts_pkg::PROD_W-1:0] res_reg [erts_pkg::NUM_STEPS];
    logic signed [FS_W-1:0]    freesp_reg;
    logic [18:0]               rpm_reg;

    // Output register.
    logic               out_valid_reg;
    logic [18:0]        out_speed_reg;
    logic signed [16:0] out_torque_reg;
    logic               out_limit_reg;

    // Unit connections.
    logic [erts_pkg::MUL_A_W-1:0] mul_a;
    logic [erts_pkg::MUL_B_W-1:0] mul_b;
    logic [erts_pkg::PROD_W-1:0]  mul_prod;
    erts_pkg::unit_stat_t         mul_stat;
    logic [erts_pkg::DIV_N_W-1:0] div_n;
    logic [erts_pkg::DIV_D_W-1:0] div_d;
    logic [erts_pkg::DIV_N_W-1:0] div_q;
    erts_pkg::unit_stat_t         div_stat;

    // Derived values.
    logic [16:0]            thr_sat;
    logic [16:0]            lock_sat;
    logic [19:0]            wheel_mag;
    logic [17:0]            ratio_mag;
    logic [16:0]            tq_mag;
    logic [17:0]            inr;
    logic [18:0]            maxd;
    logic [18:0]            peak_eff;
    logic [24:0]            geared;
    logic [24:0]            gear_sel;
    logic [24:0]            target;
    logic [33:0]            dmag;
    logic signed [FS_W-1:0] freesp_new;
    logic signed [FS_W:0]   diff;
    logic [FS_W:0]          diff_mag;
    logic [39:0]            blend_mag;
    logic signed [FS_W+4:0] rpm_raw;
    logic [18:0]            rpm_new;
    logic [18:0]            u_mag;
    logic [16:0]            curve;
    logic [16:0]            frac;
    logic [15:0]            drive;
    logic [15:0]            brake;
    logic signed [16:0]     torque_net;
    logic                   at_limit;
    logic signed [16:0]     torque_fin;

    erts_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .stat  (mul_stat)
    );

    erts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_n),
        .den   (div_d),
        .quo   (div_q),
        .stat  (div_stat)
    );

    // Saturate throttle and lock as the item is taken.
    assign thr_sat  = (in_ch.throttle > erts_pkg::ONE_Q16) ? erts_pkg::ONE_Q16
                                                           : in_ch.throttle;
    assign lock_sat = (in_ch.clutch_lock > erts_pkg::ONE_Q16) ? erts_pkg::ONE_Q16
                                                              : in_ch.clutch_lock;

    // Magnitudes and guarded divisors.
    assign wheel_mag = wheel_reg[19] ? 20'(-wheel_reg) : 20'(wheel_reg);
    assign ratio_mag = ratio_reg[17] ? 18'(-ratio_reg) : 18'(ratio_reg);
    assign tq_mag    = torque_reg[16] ? 17'(-torque_reg) : 17'(torque_reg);
    assign inr       = (inertia_reg == '0) ? 18'd1 : inertia_reg;
    assign maxd      = (max_reg == '0) ? 19'd1 : max_reg;
    assign peak_eff  = (peak_reg < erts_pkg::PEAK_MIN) ? erts_pkg::PEAK_MIN : peak_reg;

    // Geared target speed, never below idle.
    always_comb
    begin
        if (res_reg[erts_pkg::STEP_GEAR_B][63:32] > 32'(erts_pkg::GEARED_CAP))
        begin
            geared = erts_pkg::GEARED_CAP;
        end
        else
        begin
            geared = res_reg[erts_pkg::STEP_GEAR_B][56:32];
        end
        gear_sel = (engaged_reg && (ratio_reg != '0)) ? geared : 25'(idle_reg);
        target   = (gear_sel > 25'(idle_reg)) ? gear_sel : 25'(idle_reg);
    end

    // Free speed from the division result, then the clutch blend and clamp.
    always_comb
    begin
        dmag = div_q[33:0];
        if (torque_reg[16])
        begin
            freesp_new = $signed(FS_W'(speed_reg)) - $signed(FS_W'(dmag));
        end
        else
        begin
            freesp_new = $signed(FS_W'(speed_reg)) + $signed(FS_W'(dmag));
        end
        diff      = $signed((FS_W + 1)'(target)) - (FS_W + 1)'(freesp_reg);
        diff_mag  = diff[FS_W] ? (FS_W + 1)'(-diff) : (FS_W + 1)'(diff);
        blend_mag = mul_prod[55:16];
        if (diff[FS_W])
        begin
            rpm_raw = (FS_W + 5)'(freesp_reg) - $signed((FS_W + 5)'(blend_mag));
        end
        else
        begin
            rpm_raw = (FS_W + 5)'(freesp_reg) + $signed((FS_W + 5)'(blend_mag));
        end
        if (rpm_raw < $signed((FS_W + 5)'(idle_reg)))
        begin
            rpm_new = idle_reg;
        end
        else if (rpm_raw > $signed((FS_W + 5)'(max_reg)))
        begin
            rpm_new = max_reg;
        end
        else
        begin
            rpm_new = rpm_raw[18:0];
        end
    end

    // Torque curve, braking fraction, net torque and rev limit.
    always_comb
    begin
        u_mag = (rpm_reg >= peak_eff) ? 19'(rpm_reg - peak_eff) : 19'(peak_eff - rpm_reg);
        if (res_reg[erts_pkg::STEP_PEN_DIV] >= 64'(erts_pkg::PEN_MAX))
        begin
            curve = erts_pkg::CURVE_MIN;
        end
        else
        begin
            curve = 17'(erts_pkg::ONE_Q16 - res_reg[erts_pkg::STEP_PEN_DIV][16:0]);
        end
        if (res_reg[erts_pkg::STEP_FRAC] > 64'(erts_pkg::ONE_Q16))
        begin
            frac = erts_pkg::ONE_Q16;
        end
        else
        begin
            frac = res_reg[erts_pkg::STEP_FRAC][16:0];
        end
        drive      = res_reg[erts_pkg::STEP_DRIVE_B][47:32];
        brake      = res_reg[erts_pkg::STEP_BRAKE_B][47:32];
        torque_net = $signed({1'b0, drive}) - $signed({1'b0, brake});
        at_limit   = (29'(rpm_reg) * 29'd1000) >= (29'(max_reg) * 29'd995);
        torque_fin = (at_limit && (torque_net > 0)) ? '0 : torque_net;
    end

    // Operand selection for each step.
    always_comb
    begin
        mul_a       = '0;
        mul_b       = '0;
        div_n       = '0;
        div_d       = erts_pkg::DIV_D_W'(1);
        step_is_div = 1'b0;
        case (step_reg)
            erts_pkg::STEP_GEAR_A:
            begin
                mul_a = erts_pkg::MUL_A_W'(wheel_mag);
                mul_b = erts_pkg::MUL_B_W'(ratio_mag);
            end
            erts_pkg::STEP_GEAR_B:
            begin
                mul_a = res_reg[erts_pkg::STEP_GEAR_A][39:0];
                mul_b = erts_pkg::MUL_B_W'(erts_pkg::RPM_PER_RADS);
            end
            erts_pkg::STEP_ACC_A:
            begin
                mul_a = erts_pkg::MUL_A_W'(tq_mag);
                mul_b = erts_pkg::MUL_B_W'(dt_reg);
            end
            erts_pkg::STEP_ACC_B:
            begin
                mul_a = res_reg[erts_pkg::STEP_ACC_A][39:0];
                mul_b = erts_pkg::MUL_B_W'(erts_pkg::RPM_PER_RADS);
            end
            erts_pkg::STEP_ACC_DIV:
            begin
                step_is_div = 1'b1;
                div_n = erts_pkg::DIV_N_W'(res_reg[erts_pkg::STEP_ACC_B][63:20]);
                div_d = erts_pkg::DIV_D_W'(inr);
            end
            erts_pkg::STEP_BLEND:
            begin
                mul_a = erts_pkg::MUL_A_W'(diff_mag);
                mul_b = erts_pkg::MUL_B_W'(lock_reg);
            end
            erts_pkg::STEP_U_SQ:
            begin
                mul_a = erts_pkg::MUL_A_W'(u_mag);
                mul_b = erts_pkg::MUL_B_W'(u_mag);
            end
            erts_pkg::STEP_U_SQ9:
            begin
                mul_a = res_reg[erts_pkg::STEP_U_SQ][39:0];
                mul_b = erts_pkg::MUL_B_W'(9);
            end
            erts_pkg::STEP_P_SQ:
            begin
                mul_a = erts_pkg::MUL_A_W'(peak_eff);
                mul_b = erts_pkg::MUL_B_W'(peak_eff);
            end
            erts_pkg::STEP_P_SQ20:
            begin
                mul_a = res_reg[erts_pkg::STEP_P_SQ][39:0];
                mul_b = erts_pkg::MUL_B_W'(20);
            end
            erts_pkg::STEP_PEN_DIV:
            begin
                step_is_div = 1'b1;
                div_n = {res_reg[erts_pkg::STEP_U_SQ9][47:0], 16'b0};
                div_d = res_reg[erts_pkg::STEP_P_SQ20][47:0];
            end
            erts_pkg::STEP_FRAC:
            begin
                step_is_div = 1'b1;
                div_n = erts_pkg::DIV_N_W'({rpm_reg, 16'b0});
                div_d = erts_pkg::DIV_D_W'(maxd);
            end
            erts_pkg::STEP_DRIVE_A:
            begin
                mul_a = erts_pkg::MUL_A_W'(max_tq_reg);
                mul_b = erts_pkg::MUL_B_W'(curve);
            end
            erts_pkg::STEP_DRIVE_B:
            begin
                mul_a = res_reg[erts_pkg::STEP_DRIVE_A][39:0];
                mul_b = erts_pkg::MUL_B_W'(thr_reg);
            end
            erts_pkg::STEP_BRAKE_A:
            begin
                mul_a = erts_pkg::MUL_A_W'(brake_tq_reg);
                mul_b = erts_pkg::MUL_B_W'(17'(erts_pkg::ONE_Q16 - thr_reg));
            end
            erts_pkg::STEP_BRAKE_B:
            begin
                mul_a = res_reg[erts_pkg::STEP_BRAKE_A][39:0];
                mul_b = erts_pkg::MUL_B_W'(frac);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign unit_done = step_is_div ? div_stat.done : mul_stat.done;
    assign unit_res  = step_is_div ? div_q : mul_prod;
    assign slot_free = !out_valid_reg || out_ch.ready;

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= erts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and unit starts.
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            erts_pkg::S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.action || !started_reg)
                    begin
                        state_next = erts_pkg::S_EMIT;
                    end
                    else
                    begin
                        state_next = erts_pkg::S_ISSUE;
                    end
                end
            end
            erts_pkg::S_ISSUE:
            begin
                div_start  = step_is_div;
                mul_start  = !step_is_div;
                state_next = erts_pkg::S_WAIT;
            end
            erts_pkg::S_WAIT:
            begin
                if (unit_done)
                begin
                    state_next = (step_reg == erts_pkg::STEP_BRAKE_B) ? erts_pkg::S_FINAL
                                                                      : erts_pkg::S_ISSUE;
                end
            end
            erts_pkg::S_FINAL:
            begin
                state_next = erts_pkg::S_EMIT;
            end
            erts_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = erts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = erts_pkg::S_IDLE;
            end
        endcase
    end

    assign in_ch.ready = (state_reg == erts_pkg::S_IDLE);

    // Control registers: configuration, engine state, step counter, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg      <= 19'd12800;
            max_reg       <= 19'd112000;
            max_tq_reg    <= 16'd4800;
            brake_tq_reg  <= 16'd800;
            peak_reg      <= 19'd72000;
            inertia_reg   <= 18'd819;
            speed_reg     <= '0;
            torque_reg    <= '0;
            limiter_reg   <= 1'b0;
            started_reg   <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    erts_pkg::CFG_IDLE_RPM:   idle_reg     <= cfg_data;
                    erts_pkg::CFG_MAX_RPM:    max_reg      <= cfg_data;
                    erts_pkg::CFG_MAX_TORQUE: max_tq_reg   <= cfg_data[15:0];
                    erts_pkg::CFG_BRAKE_TQ:   brake_tq_reg <= cfg_data[15:0];
                    erts_pkg::CFG_PEAK_RPM:   peak_reg     <= cfg_data;
                    erts_pkg::CFG_INERTIA:    inertia_reg  <= cfg_data[17:0];
                    default:                  idle_reg     <= idle_reg;
                endcase
            end

            if ((state_reg == erts_pkg::S_IDLE) && in_ch.valid)
            begin
                step_reg <= '0;
                if (in_ch.action)
                begin
                    speed_reg   <= idle_reg;
                    started_reg <= 1'b1;
                end
            end

            if ((state_reg == erts_pkg::S_WAIT) && unit_done)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (state_reg == erts_pkg::S_FINAL)
            begin
                speed_reg   <= rpm_reg;
                torque_reg  <= torque_fin;
                limiter_reg <= at_limit;
            end

            // The output register empties when taken and fills at the end of an item.
            if ((state_reg == erts_pkg::S_EMIT) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: latched item, step results, output item.
    always_ff @(posedge clk)
    begin
        if ((state_reg == erts_pkg::S_IDLE) && in_ch.valid)
        begin
            dt_reg      <= in_ch.time_step;
            thr_reg     <= thr_sat;
            lock_reg    <= lock_sat;
            engaged_reg <= in_ch.gear_engaged;
            ratio_reg   <= in_ch.gear_ratio;
            wheel_reg   <= in_ch.wheel_speed;
        end

        if ((state_reg == erts_pkg::S_WAIT) && unit_done)
        begin
            res_reg[step_reg] <= unit_res;
            if (step_reg == erts_pkg::STEP_ACC_DIV)
            begin
                freesp_reg <= freesp_new;
            end
            if (step_reg == erts_pkg::STEP_BLEND)
            begin
                rpm_reg <= rpm_new;
            end
        end

        if ((state_reg == erts_pkg::S_EMIT) && slot_free)
        begin
            out_speed_reg  <= speed_reg;
            out_torque_reg <= torque_reg;
            out_limit_reg  <= limiter_reg;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.engine_speed      = out_speed_reg;
    assign out_ch.engine_torque_out = out_torque_reg;
    assign out_ch.limiter_on        = out_limit_reg;

    // Only one arithmetic unit runs at a time.
    `ERTS_ASSERT_NOW(a_units_exclusive, mul_stat.busy, !div_stat.busy)
    // A taken item always leaves the idle state.
    `ERTS_ASSERT_NEXT(a_accept_busy, in_ch.valid && in_ch.ready, state_reg != erts_pkg::S_IDLE)
    // At the rev limit the stored torque never drives.
    `ERTS_ASSERT_NOW(a_limit_no_drive, limiter_reg, torque_reg[16] || (torque_reg == '0))
    // A finished tick leaves the speed between idle and maximum.
    `ERTS_ASSERT_NEXT(a_speed_range, (state_reg == erts_pkg::S_FINAL) && (idle_reg <= max_reg), (speed_reg >= idle_reg) && (speed_reg <= max_reg))

endmodule

[src/erts_mul.sv]
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle.
module erts_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [erts_pkg::MUL_A_W-1:0] a,
    input  logic [erts_pkg::MUL_B_W-1:0] b,
    output logic [erts_pkg::PROD_W-1:0]  prod,
    output erts_pkg::unit_stat_t         stat
);

    localparam int unsigned CNT_W = $clog2(erts_pkg::MUL_B_W + 1);

    logic [erts_pkg::PROD_W-1:0]  acc_reg;
    logic [erts_pkg::PROD_W-1:0]  a_sh_reg;
    logic [erts_pkg::MUL_B_W-1:0] b_sh_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    // Control: bit counter and busy/done flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(erts_pkg::MUL_B_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: add the shifted multiplicand when the low multiplier bit is set.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            a_sh_reg <= erts_pkg::PROD_W'(a);
            b_sh_reg <= b;
        end
        else if (busy_reg)
        begin
            if (b_sh_reg[0])
            begin
                acc_reg <= acc_reg + a_sh_reg;
            end
            a_sh_reg <= {a_sh_reg[erts_pkg::PROD_W-2:0], 1'b0};
            b_sh_reg <= {1'b0, b_sh_reg[erts_pkg::MUL_B_W-1:1]};
        end
    end

    assign prod      = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[src/erts_div.sv]
// Restoring divider: one quotient bit per cycle, most significant first.
module erts_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [erts_pkg::DIV_N_W-1:0] num,
    input  logic [erts_pkg::DIV_D_W-1:0] den,
    output logic [erts_pkg::DIV_N_W-1:0] quo,
    output erts_pkg::unit_stat_t         stat
);

    localparam int unsigned N_W   = erts_pkg::DIV_N_W;
    localparam int unsigned D_W   = erts_pkg::DIV_D_W;
    localparam int unsigned CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   num_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[N_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // Control: bit counter and busy/done flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(N_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: numerator shifts out at the top while quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= D_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[D_W-1:0];
            end
            num_reg <= {num_reg[N_W-2:0], fits};
        end
    end

    assign quo       = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
